### rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache: table size, field
// widths, request and response payloads and the capacity clamp.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int DATA_W  = 32;
  localparam int AGE_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic signed [DATA_W-1:0] data_t;

  localparam data_t MISS_VALUE = '1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } lkv_op_t;

  typedef struct packed {
    lkv_op_t operation;
    data_t   key;
    data_t   value;
  } lkv_req_t;

  typedef struct packed {
    logic  hit;
    data_t read_value;
    logic  evicted;
    data_t evicted_key;
  } lkv_rsp_t;

  // A capacity of zero acts as one; anything above the table size saturates.
  function automatic logic [CMP_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
    logic [CMP_W-1:0] c;
    c = CMP_W'(cap);
    if (c == '0) begin
      c = CMP_W'(1);
    end else if (c > CMP_W'(ENTRIES)) begin
      c = CMP_W'(ENTRIES);
    end
    return c;
  endfunction

endpackage

### rtl/lkv_table.sv
// ----------------------------------------------------------------------------
// lkv_table
// Fully associative entry table with recency ranks. Looks up the request key
// in all entries at once, forms the response and the next table contents, and
// commits the update when upd_en is high.
// ----------------------------------------------------------------------------
module lkv_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd_en,
  input  lkv_pkg::lkv_req_t req,
  input  logic [lkv_pkg::CAP_W-1:0] capacity,
  output lkv_pkg::lkv_rsp_t rsp
);
  import lkv_pkg::*;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [AGE_W-1:0]   age_r   [ENTRIES];
  logic [AGE_W-1:0]   age_nxt [ENTRIES];
  data_t              key_r   [ENTRIES];
  data_t              key_nxt [ENTRIES];
  data_t              value_r   [ENTRIES];
  data_t              value_nxt [ENTRIES];
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic [CMP_W-1:0]   cap;
  logic [CMP_W-1:0]   cnt_ext;
  logic [AGE_W-1:0]   oldest_rank;
  logic [ENTRIES-1:0] match;
  logic               hit;
  logic [AGE_W-1:0]   hit_age;
  data_t              hit_value;
  logic [AGE_W-1:0]   age_hit [ENTRIES];
  logic [ENTRIES-1:0] ev_mask;
  logic               do_evict;
  data_t              ev_key;
  logic [ENTRIES-1:0] valid_ev;
  logic [ENTRIES-1:0] free;
  logic [ENTRIES-1:0] slot;

  assign cap         = eff_capacity(capacity);
  assign cnt_ext     = CMP_W'(count_r);
  assign oldest_rank = AGE_W'(count_r - CNT_W'(1));

  // Parallel key compare and one-hot selection of the matching entry.
  always_comb begin
    hit_age   = '0;
    hit_value = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      match[j] = valid_r[j] && (key_r[j] == req.key);
      if (match[j]) begin
        hit_age   = hit_age | age_r[j];
        hit_value = hit_value | value_r[j];
      end
    end
    hit = |match;
  end

  // Ranks after the hit entry moves to the front.
  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      if (match[j]) begin
        age_hit[j] = '0;
      end else if (valid_r[j] && (age_r[j] < hit_age)) begin
        age_hit[j] = age_r[j] + AGE_W'(1);
      end else begin
        age_hit[j] = age_r[j];
      end
    end
  end

  // On a put, a present key evicts after the touch when the table is over capacity;
  // a new key evicts before its insert when the table is at or over capacity.
  always_comb begin
    ev_key = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      ev_mask[j] = valid_r[j] && ((hit ? age_hit[j] : age_r[j]) == oldest_rank);
    end
    if (req.operation == OP_PUT) begin
      do_evict = hit ? (cnt_ext > cap) : ((cnt_ext >= cap) && (count_r != '0));
    end else begin
      do_evict = 1'b0;
    end
    for (int j = 0; j < ENTRIES; j++) begin
      if (do_evict && ev_mask[j]) begin
        ev_key = ev_key | key_r[j];
      end
    end
  end

  assign valid_ev = valid_r & ~(do_evict ? ev_mask : '0);
  assign free     = ~valid_ev;
  assign slot     = free & (~free + ENTRIES'(1));

  always_comb begin
    valid_nxt = valid_r;
    age_nxt   = age_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    count_nxt = count_r;
    unique case (req.operation)
      OP_GET: begin
        if (hit) begin
          age_nxt = age_hit;
        end
      end
      OP_PUT: begin
        if (hit) begin
          for (int j = 0; j < ENTRIES; j++) begin
            if (match[j]) begin
              value_nxt[j] = req.value;
            end
            age_nxt[j] = (do_evict && ev_mask[j]) ? '0 : age_hit[j];
          end
          valid_nxt = valid_ev;
          if (do_evict) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end else begin
          for (int j = 0; j < ENTRIES; j++) begin
            if (slot[j]) begin
              key_nxt[j]   = req.key;
              value_nxt[j] = req.value;
              age_nxt[j]   = '0;
            end else if (valid_ev[j]) begin
              age_nxt[j] = age_r[j] + AGE_W'(1);
            end else begin
              age_nxt[j] = '0;
            end
          end
          valid_nxt = valid_ev | slot;
          if (!do_evict) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_comb begin
    rsp.hit         = hit;
    rsp.evicted     = do_evict;
    rsp.evicted_key = ev_key;
    if (req.operation == OP_GET) begin
      rsp.read_value = hit ? hit_value : MISS_VALUE;
    end else begin
      rsp.read_value = req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      age_r   <= '{default: '0};
      count_r <= '0;
    end else if (upd_en) begin
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      key_r   <= key_nxt;
      value_r <= value_nxt;
    end
  end

endmodule

### rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   lkv_req_t  (operation, key, value)
//   out_     output     out_valid / out_stall lkv_rsp_t  (hit, read_value,
//                                                         evicted, evicted_key)
//   cfg_     input      cfg_valid / cfg_ready capacity, 5 bits
//
// One request per cycle while the result is not stalled; each request passes
// through the input register and then the result register. The key compare and
// rank update of the 16-entry table lie combinationally between the two.
// Reset empties the table at once through its valid bits.
// A stalled result holds the result register and backs up into in_stall.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lkv_pkg::lkv_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lkv_pkg::lkv_rsp_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data
);
  import lkv_pkg::*;

  logic             in_vld_r, in_vld_nxt;
  lkv_req_t         in_req_r;
  logic             out_vld_r, out_vld_nxt;
  lkv_rsp_t         out_rsp_r;
  logic [CAP_W-1:0] capacity_r;
  logic             advance;
  logic             in_take;
  lkv_rsp_t         rsp;

  assign advance     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall    = in_vld_r && !advance;
  assign in_take     = in_valid && !in_stall;
  assign in_vld_nxt  = in_take || (in_vld_r && !advance);
  assign out_vld_nxt = advance || (out_vld_r && out_stall);

  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_rsp_r;

  lkv_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en   (advance),
    .req      (in_req_r),
    .capacity (capacity_r),
    .rsp      (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      capacity_r <= CAP_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req_r <= in_data;
    end
    if (advance) begin
      out_rsp_r <= rsp;
    end
  end

endmodule

### rtl/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks for the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkv_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input lkv_pkg::lkv_req_t in_data,
  input logic              out_valid,
  input logic              out_stall,
  input lkv_pkg::lkv_rsp_t out_data
);
  import lkv_pkg::*;

  // A held result keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The input side only backs up behind a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A put transfer whose result path is free passes on to the result register and
  // reports the value it stored.
  a_put_value: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.operation == OP_PUT) ##1 !out_stall
    |=> out_valid && (out_data.read_value == $past(in_data.value, 2)))
    else $error("put result missing or wrong value");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
